### src/text_console_writer_defines.svh
// Assertion macros used by the console writer checker
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// check sampled on the rising clock, skipped while reset is high
`define TCW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// check sampled on the rising clock, active during reset as well
`define TCW_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

### src/tcw_pkg.sv
// Types, codes and constants of the text console writer
package tcw_pkg;

   localparam int CHAR_W = 8;
   localparam int CELL_W = 16;
   localparam int POS_W  = 11;

   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h0F;

   // request actions
   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // sweep counter operations
   localparam logic [1:0] SW_HOLD   = 2'd0;
   localparam logic [1:0] SW_ZERO   = 2'd1;
   localparam logic [1:0] SW_BOTTOM = 2'd2;
   localparam logic [1:0] SW_STEP   = 2'd3;

   // cell write sources
   localparam logic [1:0] WR_NONE        = 2'd0;
   localparam logic [1:0] WR_RESET_BLANK = 2'd1;
   localparam logic [1:0] WR_COLOR_BLANK = 2'd2;
   localparam logic [1:0] WR_CHAR        = 2'd3;

   // cursor operations
   localparam logic [1:0] CUR_HOLD     = 2'd0;
   localparam logic [1:0] CUR_HOME     = 2'd1;
   localparam logic [1:0] CUR_NEXT_COL = 2'd2;
   localparam logic [1:0] CUR_NEW_LINE = 2'd3;

   typedef struct packed {
      logic [1:0]        action;
      logic [CHAR_W-1:0] char_code;
      logic [10:0]       cell_address;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_position;
      logic [CELL_W-1:0] cell_value;
   } rsp_type;

   typedef struct packed {
      logic       latch;
      logic [1:0] sweep_op;
      logic [1:0] write_sel;
      logic       copy_read;
      logic [1:0] cursor_op;
      logic       respond;
      logic       respond_read;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       is_newline;
      logic       col_last;
      logic       row_last;
      logic       sweep_at_end;
      logic       sweep_at_copy_end;
   } status_type;

endpackage

### src/text_console_writer.sv
// Text console writer top level: controller plus cell-store datapath
//
//   channel  | handshake                 | payload
//   request  | start in, busy out        | req_data (action, char_code, cell_address)
//   result   | rsp_valid strobe out      | rsp_data (cursor_position, cell_value)
//   config   | csr_valid in, csr_ready   | csr_data (text color attribute)
//
// From the execute state, a put that does not scroll and action 3 go to the respond
// state and a read to the read state; both register the result strobe. Clear writes
// one cell a cycle on the single RAM write port. A put that scrolls does a pipelined
// row-up copy, one cell a cycle, then a walk over the bottom row.
// After reset, busy stays high while every cell is set to a blank in the reset color;
// color writes are taken during that pass.
// The result strobe lasts one cycle and cannot be stalled.
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CHAR_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   tcw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### src/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/tcw_ctrl.sv
// Sequencing state machine of the text console writer
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_INIT    = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_EXEC    = 4'd2;
   localparam logic [3:0] S_FILL    = 4'd3;
   localparam logic [3:0] S_COPY    = 4'd4;
   localparam logic [3:0] S_DRAIN   = 4'd5;
   localparam logic [3:0] S_BLANK   = 4'd6;
   localparam logic [3:0] S_READ    = 4'd7;
   localparam logic [3:0] S_RESPOND = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in         = state_ff;
      cmd.latch        = 1'b0;
      cmd.sweep_op     = SW_HOLD;
      cmd.write_sel    = WR_NONE;
      cmd.copy_read    = 1'b0;
      cmd.cursor_op    = CUR_HOLD;
      cmd.respond      = 1'b0;
      cmd.respond_read = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.write_sel = WR_RESET_BLANK;
            cmd.sweep_op  = SW_STEP;
            if (status.sweep_at_end) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            case (status.action)
               ACT_PUT: begin
                  if (!status.is_newline) begin
                     cmd.write_sel = WR_CHAR;
                  end
                  if (status.is_newline || status.col_last) begin
                     cmd.cursor_op = CUR_NEW_LINE;
                     if (status.row_last) begin
                        cmd.sweep_op = SW_ZERO;
                        state_in     = S_COPY;
                     end else begin
                        state_in = S_RESPOND;
                     end
                  end else begin
                     cmd.cursor_op = CUR_NEXT_COL;
                     state_in      = S_RESPOND;
                  end
               end
               ACT_CLEAR: begin
                  cmd.cursor_op = CUR_HOME;
                  cmd.sweep_op  = SW_ZERO;
                  state_in      = S_FILL;
               end
               ACT_READ: begin
                  state_in = S_READ;
               end
               default: begin
                  state_in = S_RESPOND;
               end
            endcase
         end
         S_FILL: begin
            cmd.write_sel = WR_COLOR_BLANK;
            cmd.sweep_op  = SW_STEP;
            if (status.sweep_at_end) begin
               state_in = S_RESPOND;
            end
         end
         S_COPY: begin
            cmd.copy_read = 1'b1;
            cmd.sweep_op  = SW_STEP;
            if (status.sweep_at_copy_end) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last copied cell goes to the RAM this cycle
            cmd.sweep_op = SW_BOTTOM;
            state_in     = S_BLANK;
         end
         S_BLANK: begin
            cmd.write_sel = WR_COLOR_BLANK;
            cmd.sweep_op  = SW_STEP;
            if (status.sweep_at_end) begin
               state_in = S_RESPOND;
            end
         end
         S_READ: begin
            cmd.respond      = 1'b1;
            cmd.respond_read = 1'b1;
            state_in         = S_IDLE;
         end
         S_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### src/tcw_datapath.sv
// Cell store, cursor, sweep counter and result registers of the console writer
module tcw_datapath
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_data,
   input  logic              csr_write,
   input  logic [CHAR_W-1:0] csr_data,
   input  cmd_type           cmd,
   output status_type        status,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int WW    = AW + POS_W;

   req_type           req_ff;
   logic [CHAR_W-1:0] color_ff;
   logic [RW-1:0]     row_ff;
   logic [CW-1:0]     col_ff;
   logic [AW-1:0]     sweep_ff;
   logic              copy_pend_ff;
   logic [AW-1:0]     copy_addr_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic [AW-1:0]     cur_pos;
   logic [WW-1:0]     pos_wide;
   logic [WW-1:0]     addr_wide;
   logic              addr_in_range;
   logic              col_last;
   logic              row_last;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr;
   logic [CELL_W-1:0] mem_rdata;

   assign cur_pos       = AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff);
   assign pos_wide      = WW'(cur_pos);
   assign addr_wide     = WW'(req_ff.cell_address);
   assign addr_in_range = (addr_wide < WW'(CELLS));
   assign col_last      = (col_ff == CW'(COLUMNS - 1));
   assign row_last      = (row_ff == RW'(ROWS - 1));

   assign status.action            = req_ff.action;
   assign status.is_newline        = (req_ff.char_code == NEWLINE_CHAR);
   assign status.col_last          = col_last;
   assign status.row_last          = row_last;
   assign status.sweep_at_end      = (sweep_ff == AW'(CELLS - 1));
   assign status.sweep_at_copy_end = (sweep_ff == AW'(CELLS - COLUMNS - 1));

   // scroll copy reads one row ahead of the write address
   assign mem_raddr = cmd.copy_read ? (sweep_ff + AW'(COLUMNS)) : addr_wide[AW-1:0];

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = sweep_ff;
      mem_wdata = {RESET_COLOR, BLANK_CHAR};
      if (copy_pend_ff) begin
         mem_we    = 1'b1;
         mem_waddr = copy_addr_ff;
         mem_wdata = mem_rdata;
      end else begin
         case (cmd.write_sel)
            WR_RESET_BLANK: begin
               mem_we = 1'b1;
            end
            WR_COLOR_BLANK: begin
               mem_we    = 1'b1;
               mem_wdata = {color_ff, BLANK_CHAR};
            end
            WR_CHAR: begin
               mem_we    = 1'b1;
               mem_waddr = cur_pos;
               mem_wdata = {color_ff, req_ff.char_code};
            end
            default: begin
               mem_we = 1'b0;
            end
         endcase
      end
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= RESET_COLOR;
         row_ff       <= '0;
         col_ff       <= '0;
         sweep_ff     <= '0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            color_ff <= csr_data;
         end
         case (cmd.cursor_op)
            CUR_HOME: begin
               row_ff <= '0;
               col_ff <= '0;
            end
            CUR_NEXT_COL: begin
               col_ff <= col_ff + 1'b1;
            end
            CUR_NEW_LINE: begin
               col_ff <= '0;
               if (!row_last) begin
                  row_ff <= row_ff + 1'b1;
               end
            end
            default: begin
               row_ff <= row_ff;
            end
         endcase
         case (cmd.sweep_op)
            SW_ZERO:   sweep_ff <= '0;
            SW_BOTTOM: sweep_ff <= AW'(CELLS - COLUMNS);
            SW_STEP:   sweep_ff <= sweep_ff + 1'b1;
            default:   sweep_ff <= sweep_ff;
         endcase
         copy_pend_ff <= cmd.copy_read;
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      if (cmd.copy_read) begin
         copy_addr_ff <= sweep_ff;
      end
      if (cmd.respond) begin
         rsp_ff.cursor_position <= pos_wide[POS_W-1:0];
         rsp_ff.cell_value      <= (cmd.respond_read && addr_in_range) ? mem_rdata : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### src/tcw_checker.sv
// Port-level checks of the text console writer and their bind
`include "text_console_writer_defines.svh"

module tcw_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // reset starts the blanking pass
   `TCW_ASSERT_ALWAYS(a_reset_busy, clock, reset |=> busy)

   // an accepted transfer keeps the block busy next cycle
   `TCW_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy)

   // results only appear once the work is done
   `TCW_ASSERT(a_rsp_idle, clock, reset, rsp_valid |-> !busy)

   // no two result strobes in a row
   `TCW_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid)

endmodule

bind text_console_writer tcw_checker u_checker (.*);
